// ===== design/irc_ltd_pkg.sv =====
// ----------------------------------------------------------------------------
// IRC line tokenizer package
// Role, verdict and parse phase codes, and the command word table.
// ----------------------------------------------------------------------------
package irc_ltd_pkg;

	localparam int unsigned MaxTokensDefault = 15;
	localparam int unsigned NumWords = 8;
	localparam int unsigned WordChars = 8;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_PREFIX = 8'b0000_0010,
		PH_PRECMD = 8'b0000_0100,
		PH_CMD    = 8'b0000_1000,
		PH_GAP    = 8'b0001_0000,
		PH_PARAM  = 8'b0010_0000,
		PH_TRAIL  = 8'b0100_0000,
		PH_DROP   = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_END    = 3'd0,
		ROLE_PREFIX = 3'd1,
		ROLE_CMD    = 3'd2,
		ROLE_PARAM  = 3'd3,
		ROLE_TRAIL  = 3'd4,
		ROLE_DELIM  = 3'd5,
		ROLE_DROP   = 3'd6
	} role_t;

	typedef enum logic [2:0] {
		VERD_DISPATCH   = 3'd0,
		VERD_EMPTY      = 3'd1,
		VERD_NO_CMD     = 3'd2,
		VERD_UNKNOWN    = 3'd3,
		VERD_NOT_REG    = 3'd4,
		VERD_FEW_PARAMS = 3'd5
	} verdict_t;

	localparam logic [7:0] WORD_TEXT [NumWords][WordChars] = '{
		'{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"Q", "U", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"L", "I", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "R", "I", "V", "M", "S", "G", 8'h00},
		'{"W", "H", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] WORD_LEN [NumWords] = '{
		4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd3
	};

	localparam logic [3:0] WORD_MIN_PARAMS [NumWords] = '{
		4'd0, 4'd4, 4'd0, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0
	};

	// bit k set: word k needs a registered client
	localparam logic [NumWords-1:0] WORD_NEED_REG = 8'b1111_1100;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
			return c & ~CASE_BIT;
		end
		return c;
	endfunction

endpackage

// ===== design/irc_ltd_in_if.sv =====
// ----------------------------------------------------------------------------
// IRC line tokenizer input channel
// Valid/ready channel carrying one line byte or an end item.
// ----------------------------------------------------------------------------
interface irc_ltd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_end;
	logic       client_registered;

	modport source (output valid, output line_byte, output line_end,
		output client_registered, input ready);
	modport sink (input valid, input line_byte, input line_end,
		input client_registered, output ready);
endinterface

// ===== design/irc_ltd_out_if.sv =====
// ----------------------------------------------------------------------------
// IRC line tokenizer output channel
// Valid/ready channel carrying the byte role and the line verdict.
// ----------------------------------------------------------------------------
interface irc_ltd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] byte_role;
	logic [3:0] param_index;
	logic       verdict_valid;
	logic [2:0] verdict;
	logic [2:0] command_id;
	logic [3:0] param_count;

	modport source (output valid, output byte_role, output param_index,
		output verdict_valid, output verdict, output command_id,
		output param_count, input ready);
	modport sink (input valid, input byte_role, input param_index,
		input verdict_valid, input verdict, input command_id,
		input param_count, output ready);
endinterface

// ===== design/irc_line_tokenizer_dispatcher.sv =====
// ----------------------------------------------------------------------------
// IRC line tokenizer and command dispatcher
// Tags each byte of a line with its role and gives a verdict on the end item.
// ----------------------------------------------------------------------------
// One item per clock cycle while each result is taken. An item is captured
// into an input register; as it leaves that register, its role (and, on an
// end item, the verdict, command number and parameter count) is written
// into the output register. The line state (parse phase, command match
// mask, command length, parameter count) updates as the item leaves the
// input register, so each result depends only on that state and the item
// itself. The input side stalls only while the output register holds a
// result that is not taken.
module irc_line_tokenizer_dispatcher #(
	parameter int unsigned MAX_TOKENS = irc_ltd_pkg::MaxTokensDefault
) (
	input  logic   clk,
	input  logic   arst_n,
	irc_ltd_in_if.sink    in_ch,
	irc_ltd_out_if.source out_ch
);
	import irc_ltd_pkg::*;

	logic       valid_s1;
	logic [7:0] line_byte_s1;
	logic       line_end_s1;
	logic       client_registered_s1;

	phase_t              phase_q;
	logic [NumWords-1:0] match_q;
	logic [3:0]          cmd_len_q;
	logic [3:0]          param_total_q;
	logic                nonempty_q;

	phase_t              phase_d;
	logic [NumWords-1:0] match_d;
	logic [3:0]          cmd_len_d;
	logic [3:0]          param_total_d;
	logic                nonempty_d;

	logic                out_valid_q;
	role_t               role_q;
	logic [3:0]          pidx_q;
	logic                vvalid_q;
	verdict_t            verdict_q;
	logic [2:0]          cid_q;
	logic [3:0]          pcount_q;

	role_t               role_d;
	logic [3:0]          pidx_d;
	logic                vvalid_d;
	verdict_t            verdict_d;
	logic [2:0]          cid_d;
	logic [3:0]          pcount_d;

	logic                s1_move;
	logic                cmd_step;
	logic [7:0]          upper_byte;
	logic [NumWords-1:0] char_hit;
	logic                word_found;
	logic [2:0]          word_id;
	logic                at_cap;

	assign s1_move     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_move;
	assign upper_byte  = to_upper(line_byte_s1);
	assign at_cap      = param_total_q >= 4'(MAX_TOKENS);

	always_comb begin
		for (int k = 0; k < NumWords; k++) begin
			char_hit[k] = (cmd_len_q < WORD_LEN[k]) &&
				(WORD_TEXT[k][cmd_len_q[2:0]] == upper_byte);
		end
	end

	always_comb begin
		word_found = 1'b0;
		word_id    = '0;
		for (int k = NumWords - 1; k >= 0; k--) begin
			if (match_q[k] && cmd_len_q == WORD_LEN[k]) begin
				word_found = 1'b1;
				word_id    = 3'(k);
			end
		end
	end

	always_comb begin
		role_d        = ROLE_DROP;
		pidx_d        = '0;
		vvalid_d      = 1'b0;
		verdict_d     = VERD_DISPATCH;
		cid_d         = '0;
		pcount_d      = '0;
		phase_d       = phase_q;
		match_d       = match_q;
		cmd_len_d     = cmd_len_q;
		param_total_d = param_total_q;
		nonempty_d    = nonempty_q;
		cmd_step      = 1'b0;
		if (line_end_s1) begin
			role_d   = ROLE_END;
			vvalid_d = 1'b1;
			if (!nonempty_q) begin
				verdict_d = VERD_EMPTY;
			end else if (phase_q inside {PH_START, PH_PREFIX, PH_PRECMD}) begin
				verdict_d = VERD_NO_CMD;
			end else begin
				pcount_d = param_total_q;
				if (!word_found) begin
					verdict_d = VERD_UNKNOWN;
				end else begin
					cid_d = word_id;
					if (WORD_NEED_REG[word_id] && !client_registered_s1) begin
						verdict_d = VERD_NOT_REG;
					end else if (param_total_q < WORD_MIN_PARAMS[word_id]) begin
						verdict_d = VERD_FEW_PARAMS;
					end
				end
			end
			phase_d       = PH_START;
			match_d       = '1;
			cmd_len_d     = '0;
			param_total_d = '0;
			nonempty_d    = 1'b0;
		end else if (line_byte_s1 != 8'h00) begin
			nonempty_d = 1'b1;
			case (phase_q)
				PH_START: begin
					if (line_byte_s1 == CHAR_COLON) begin
						role_d  = ROLE_PREFIX;
						phase_d = PH_PREFIX;
					end else if (line_byte_s1 == CHAR_SPACE) begin
						role_d  = ROLE_DELIM;
						phase_d = PH_PRECMD;
					end else begin
						role_d   = ROLE_CMD;
						cmd_step = 1'b1;
						phase_d  = PH_CMD;
					end
				end
				PH_PREFIX: begin
					if (line_byte_s1 == CHAR_SPACE) begin
						role_d  = ROLE_DELIM;
						phase_d = PH_PRECMD;
					end else begin
						role_d = ROLE_PREFIX;
					end
				end
				PH_PRECMD: begin
					if (line_byte_s1 == CHAR_SPACE) begin
						role_d = ROLE_DELIM;
					end else begin
						role_d   = ROLE_CMD;
						cmd_step = 1'b1;
						phase_d  = PH_CMD;
					end
				end
				PH_CMD: begin
					if (line_byte_s1 == CHAR_SPACE) begin
						role_d  = ROLE_DELIM;
						phase_d = PH_GAP;
					end else begin
						role_d   = ROLE_CMD;
						cmd_step = 1'b1;
					end
				end
				PH_GAP: begin
					if (line_byte_s1 == CHAR_SPACE) begin
						role_d = ROLE_DELIM;
					end else if (at_cap) begin
						role_d  = ROLE_DROP;
						phase_d = PH_DROP;
					end else if (line_byte_s1 == CHAR_COLON) begin
						role_d        = ROLE_DELIM;
						param_total_d = param_total_q + 4'd1;
						phase_d       = PH_TRAIL;
					end else begin
						role_d        = ROLE_PARAM;
						pidx_d        = param_total_q;
						param_total_d = param_total_q + 4'd1;
						phase_d       = PH_PARAM;
					end
				end
				PH_PARAM: begin
					if (line_byte_s1 == CHAR_SPACE) begin
						role_d  = ROLE_DELIM;
						phase_d = PH_GAP;
					end else begin
						role_d = ROLE_PARAM;
						pidx_d = param_total_q - 4'd1;
					end
				end
				PH_TRAIL: begin
					role_d = ROLE_TRAIL;
					pidx_d = param_total_q - 4'd1;
				end
				default: begin
					role_d = ROLE_DROP;
				end
			endcase
		end
		if (cmd_step) begin
			match_d = match_q & char_hit;
			if (cmd_len_q != 4'hF) begin
				cmd_len_d = cmd_len_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			line_byte_s1         <= in_ch.line_byte;
			line_end_s1          <= in_ch.line_end;
			client_registered_s1 <= in_ch.client_registered;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			match_q       <= '1;
			cmd_len_q     <= '0;
			param_total_q <= '0;
			nonempty_q    <= 1'b0;
		end else if (s1_move) begin
			phase_q       <= phase_d;
			match_q       <= match_d;
			cmd_len_q     <= cmd_len_d;
			param_total_q <= param_total_d;
			nonempty_q    <= nonempty_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			role_q    <= role_d;
			pidx_q    <= pidx_d;
			vvalid_q  <= vvalid_d;
			verdict_q <= verdict_d;
			cid_q     <= cid_d;
			pcount_q  <= pcount_d;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.byte_role     = role_q;
	assign out_ch.param_index   = pidx_q;
	assign out_ch.verdict_valid = vvalid_q;
	assign out_ch.verdict       = verdict_q;
	assign out_ch.command_id    = cid_q;
	assign out_ch.param_count   = pcount_q;

`ifndef ASSERT_OFF
	a_verdict_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (vvalid_q == (role_q == ROLE_END)))
		else $error("verdict_valid does not match end role");

	a_byte_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !vvalid_q) |->
		(verdict_q == VERD_DISPATCH && cid_q == 3'd0 && pcount_q == 4'd0))
		else $error("byte item carries verdict fields");

	a_param_cap: assert property (@(posedge clk) disable iff (!arst_n)
		param_total_q <= 4'(MAX_TOKENS))
		else $error("parameter count above cap");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && line_end_s1) |=>
		(phase_q == PH_START && param_total_q == 4'd0 && !nonempty_q &&
		cmd_len_q == 4'd0))
		else $error("line state not cleared after end item");

	a_no_drop_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ch.ready) |=> $stable(phase_q))
		else $error("line state moved while output stalled");
`endif

endmodule
